// ===== rtl/ecd_pkg.sv =====
// shared types, sizes, codes and compare helpers for the earliest completion dispatcher
package ecd_pkg;

    localparam int MAX_MACHINES = 32;
    localparam int TIME_WIDTH   = 32;
    localparam int LAT_WIDTH    = 16;

    localparam int IDX_W   = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
    localparam int CNT_W   = $clog2(MAX_MACHINES + 1);
    localparam int CHILD_W = IDX_W + 2;

    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [CHILD_W-1:0] child_t;
    typedef logic [TIME_WIDTH-1:0] time_t;
    typedef logic [LAT_WIDTH-1:0]  lat_t;

    typedef struct packed {
        time_t comp;
        lat_t  lat;
    } entry_t;

    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_PRODUCE = 2'd1;
    localparam logic [1:0] REQ_CLEAR   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam time_t TIME_MAX = '1;

    // true when a must leave before b
    function automatic logic earlier(input entry_t a, input entry_t b);
        if (a.comp != b.comp)
        begin
            return a.comp < b.comp;
        end
        return a.lat < b.lat;
    endfunction

    // completion plus latency, held at the largest time value
    function automatic time_t advance(input entry_t e);
        logic [TIME_WIDTH:0] sum;
        sum = {1'b0, e.comp} + (TIME_WIDTH + 1)'(e.lat);
        if (sum[TIME_WIDTH])
        begin
            return TIME_MAX;
        end
        return sum[TIME_WIDTH-1:0];
    endfunction

endpackage

// ===== rtl/earliest_completion_dispatcher_unit.sv =====
// earliest completion dispatcher: machine min-heap in a synchronous memory with hole-based sifts
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------
//  request  | start, busy (accept when  | req_type, latency
//           | start high and busy low)  |
//  result   | done (one-cycle strobe)   | completion, status
//
// handling of each request type up to the result strobe
// load: each heap level climbed takes a parent read (S_UP_RD) and a compare-and-write
// (S_UP_CMP); the new entry is written at the root or where the climb stops
// produce: S_ROOT takes the root, then each level descended takes a read of both
// children (S_DN_RD) and a compare-and-write (S_DN_CMP) on the registered memory reads
// clear, full, empty and unused requests: result on the next cycle
// reset clears the machine count and control; heap memory is not cleared
// results cannot be stalled; busy holds off requests until the result strobe
module earliest_completion_dispatcher_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  logic [1:0]     req_type,
    input  ecd_pkg::lat_t  latency,
    output logic           done,
    output ecd_pkg::time_t completion,
    output logic [1:0]     status
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_UP_RD  = 6'b000010,
        S_UP_CMP = 6'b000100,
        S_ROOT   = 6'b001000,
        S_DN_RD  = 6'b010000,
        S_DN_CMP = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    ecd_pkg::idx_t      idx_reg, idx_next;
    ecd_pkg::cnt_t      count_reg, count_next;
    ecd_pkg::entry_t    x_reg, x_next;
    logic               done_reg, done_next;
    ecd_pkg::time_t     completion_reg, completion_next;
    logic [1:0]         status_reg, status_next;

    ecd_pkg::entry_t    heap_mem [ecd_pkg::MAX_MACHINES];
    ecd_pkg::entry_t    rd_a_reg, rd_b_reg;
    ecd_pkg::idx_t      rd_a_addr, rd_b_addr, wr_addr;
    ecd_pkg::entry_t    wr_data;
    logic               wr_en;

    ecd_pkg::idx_t      parent_dec;
    ecd_pkg::idx_t      parent_idx;
    ecd_pkg::child_t    left_idx, right_idx;
    logic               left_ok, right_ok;
    logic               take_left, take_right;
    ecd_pkg::entry_t    after_left;

    // heap memory, one write and two registered reads
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            heap_mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= heap_mem[rd_a_addr];
        rd_b_reg <= heap_mem[rd_b_addr];
    end

    assign parent_dec = idx_reg - ecd_pkg::idx_t'(1);
    assign parent_idx = parent_dec >> 1;
    assign left_idx   = {1'b0, idx_reg, 1'b1};
    assign right_idx  = left_idx + ecd_pkg::child_t'(1);
    assign left_ok    = left_idx < ecd_pkg::child_t'(count_reg);
    assign right_ok   = right_idx < ecd_pkg::child_t'(count_reg);
    assign take_left  = left_ok && ecd_pkg::earlier(rd_a_reg, x_reg);
    assign after_left = take_left ? rd_a_reg : x_reg;
    assign take_right = right_ok && ecd_pkg::earlier(rd_b_reg, after_left);

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        x_next          = x_reg;
        done_next       = 1'b0;
        completion_next = completion_reg;
        status_next     = status_reg;
        rd_a_addr       = '0;
        rd_b_addr       = '0;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = x_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    completion_next = '0;
                    status_next     = ecd_pkg::ST_OK;
                    priority if (req_type == ecd_pkg::REQ_LOAD)
                    begin
                        if (count_reg == ecd_pkg::cnt_t'(ecd_pkg::MAX_MACHINES))
                        begin
                            status_next = ecd_pkg::ST_FULL;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            x_next.comp = ecd_pkg::time_t'(latency);
                            x_next.lat  = latency;
                            idx_next    = count_reg[ecd_pkg::IDX_W-1:0];
                            count_next  = count_reg + ecd_pkg::cnt_t'(1);
                            state_next  = S_UP_RD;
                        end
                    end
                    else if (req_type == ecd_pkg::REQ_PRODUCE)
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ecd_pkg::ST_EMPTY;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            state_next = S_ROOT;
                        end
                    end
                    else if (req_type == ecd_pkg::REQ_CLEAR)
                    begin
                        count_next = '0;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
            end
            S_UP_RD:
            begin
                if (idx_reg == '0)
                begin
                    wr_en      = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_a_addr  = parent_idx;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                wr_en = 1'b1;
                if (ecd_pkg::earlier(x_reg, rd_a_reg))
                begin
                    wr_data    = rd_a_reg;
                    idx_next   = parent_idx;
                    state_next = S_UP_RD;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_ROOT:
            begin
                completion_next = rd_a_reg.comp;
                x_next.comp     = ecd_pkg::advance(rd_a_reg);
                x_next.lat      = rd_a_reg.lat;
                idx_next        = '0;
                state_next      = S_DN_RD;
            end
            S_DN_RD:
            begin
                rd_a_addr  = left_idx[ecd_pkg::IDX_W-1:0];
                rd_b_addr  = right_idx[ecd_pkg::IDX_W-1:0];
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                wr_en = 1'b1;
                priority if (take_right)
                begin
                    wr_data    = rd_b_reg;
                    idx_next   = right_idx[ecd_pkg::IDX_W-1:0];
                    state_next = S_DN_RD;
                end
                else if (take_left)
                begin
                    wr_data    = rd_a_reg;
                    idx_next   = left_idx[ecd_pkg::IDX_W-1:0];
                    state_next = S_DN_RD;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        x_reg          <= x_next;
        completion_reg <= completion_next;
        status_reg     <= status_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign completion = completion_reg;
    assign status     = status_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE)
        else $error("result strobe outside idle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ecd_pkg::cnt_t'(ecd_pkg::MAX_MACHINES))
        else $error("machine count above table size");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req_type == ecd_pkg::REQ_CLEAR
        |=> done_reg && count_reg == '0 && status_reg == ecd_pkg::ST_OK)
        else $error("clear request did not empty the table");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req_type == ecd_pkg::REQ_PRODUCE && count_reg == '0
        |=> done_reg && status_reg == ecd_pkg::ST_EMPTY && completion_reg == '0)
        else $error("produce on empty table not reported");

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

endmodule
